FILE: src/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants for the bucket counting sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package csb_pkg;

  localparam int unsigned MaxBucketsDef  = 256;
  localparam int unsigned MaxElementsDef = 1048576;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ValW    = 64;
  localparam int unsigned PosW    = 20;
  localparam int unsigned StatusW = 2;
  localparam int unsigned BitsW   = 4;

  localparam logic [BitsW-1:0] BitsReset = 4'd8;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_COUNT  = 2'd1,
    OP_PREFIX = 2'd2,
    OP_PLACE  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;  // capture op and element
    logic idx_clr;    // walk index and running sum to zero
    logic idx_inc;
    logic rd_bucket;  // read at the item's bucket instead of the walk index
    logic wr_zero;
    logic wr_prefix;
    logic wr_rmw;     // count/place update at the item's bucket
    logic emit;       // register the result and strobe it next cycle
  } csb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_clear;
    logic last_prefix;
  } csb_sts_t;

endpackage

`default_nettype wire

FILE: src/csb_ram.sv
// ----------------------------------------------------------------------------
// csb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/csb_ctrl.sv
// ----------------------------------------------------------------------------
// csb_ctrl
// Sequencer for the counting sort engine: reset clearing pass, clear sweep,
// prefix walk and single-bucket read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_ctrl import csb_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire logic [OpW-1:0] op_i,
  input  wire csb_sts_t       sts_i,
  output csb_cmd_t            cmd_o,
  output logic                busy
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CLEAR  = 7'b0000100,
    S_PRE_RD = 7'b0001000,
    S_PRE_WR = 7'b0010000,
    S_RMW_RD = 7'b0100000,
    S_RMW_WR = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        // memory wipe after reset, no result
        cmd_o.wr_zero = 1'b1;
        if (sts_i.last_clear) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load_item = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          case (op_e'(op_i))
            OP_CLEAR:  state_d = S_CLEAR;
            OP_PREFIX: state_d = S_PRE_RD;
            default:   state_d = S_RMW_RD;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.wr_zero = 1'b1;
        if (sts_i.last_clear) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_PRE_RD: begin
        state_d = S_PRE_WR;
      end
      S_PRE_WR: begin
        cmd_o.wr_prefix = 1'b1;
        if (sts_i.last_prefix) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_PRE_RD;
        end
      end
      S_RMW_RD: begin
        cmd_o.rd_bucket = 1'b1;
        state_d         = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd_o.wr_rmw = 1'b1;
        cmd_o.emit   = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: src/csb_datapath.sv
// ----------------------------------------------------------------------------
// csb_datapath
// Bucket counter memory, walk index, running sum, bucket select and result
// registers of the counting sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_datapath import csb_pkg::*; #(
  parameter int unsigned MAX_BUCKETS  = MaxBucketsDef,
  parameter int unsigned MAX_ELEMENTS = MaxElementsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire csb_cmd_t         cmd_i,
  output csb_sts_t              sts_o,
  input  wire logic [OpW-1:0]   op_i,
  input  wire logic [ValW-1:0]  element_value_i,
  input  wire logic             cfg_we_i,
  input  wire logic [BitsW-1:0] cfg_wdata_i,
  output logic [PosW-1:0]       position_o,
  output logic [ValW-1:0]       value_o,
  output logic [StatusW-1:0]    status_o,
  output logic                  result_valid_o
);

  localparam int unsigned AW      = $clog2(MAX_BUCKETS);
  localparam int unsigned CW      = $clog2(MAX_ELEMENTS + 1);
  // largest bucket_bits whose bucket count still fits
  localparam int unsigned MaxBits = $clog2(MAX_BUCKETS + 1) - 1;

  logic [BitsW-1:0] bucket_bits_q;
  op_e              op_q;
  logic [ValW-1:0]  elem_q;
  logic [AW-1:0]    idx_q;
  logic [CW-1:0]    run_q;

  logic [BitsW-1:0] bits_eff;
  logic [AW-1:0]    bkt_mask;
  logic [AW-1:0]    bucket;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_bits_q <= BitsReset;
    end else if (cfg_we_i) begin
      bucket_bits_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= op_e'(op_i);
      elem_q <= element_value_i;
    end
  end

  assign bits_eff = (bucket_bits_q > BitsW'(MaxBits)) ? BitsW'(MaxBits) : bucket_bits_q;
  assign bkt_mask = ~({AW{1'b1}} << bits_eff);
  assign bucket   = elem_q[AW-1:0] & bkt_mask;

  assign sts_o.last_clear  = (idx_q == AW'(MAX_BUCKETS - 1));
  assign sts_o.last_prefix = (idx_q == bkt_mask);

  // counter memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] cur;

  csb_ram #(
    .Width (CW),
    .Depth (MAX_BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (cur)
  );

  // running sum, saturating
  logic [CW:0]   sum;
  logic [CW-1:0] sum_sat;
  assign sum     = {1'b0, run_q} + {1'b0, cur};
  assign sum_sat = (sum > (CW+1)'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : sum[CW-1:0];

  // walk index starts at zero out of reset for the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      run_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
      run_q <= '0;
    end else begin
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.wr_prefix) begin
        run_q <= sum_sat;
      end
    end
  end

  // single-bucket update
  logic          is_count;
  logic          is_place;
  logic          sat;
  logic          empty;
  logic [CW-1:0] cur_dec;
  logic [CW+PosW-1:0] pos_ext;

  assign is_count = (op_q == OP_COUNT);
  assign is_place = (op_q == OP_PLACE);
  assign sat      = is_count && (cur >= CW'(MAX_ELEMENTS));
  assign empty    = is_place && (cur == '0);
  assign cur_dec  = cur - CW'(1);
  assign pos_ext  = {{PosW{1'b0}}, cur_dec};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    if (cmd_i.wr_zero) begin
      ram_we = 1'b1;
    end else if (cmd_i.wr_prefix) begin
      ram_we    = 1'b1;
      ram_wdata = sum_sat;
    end else if (cmd_i.wr_rmw) begin
      ram_we    = !(sat || empty);
      ram_waddr = bucket;
      ram_wdata = is_count ? (cur + CW'(1)) : cur_dec;
    end
  end

  assign ram_raddr = cmd_i.rd_bucket ? bucket : idx_q;

  // result registers
  logic                result_valid_q;
  logic [PosW-1:0]     pos_q,    pos_d;
  logic [ValW-1:0]     val_q,    val_d;
  logic [StatusW-1:0]  status_q, status_d;

  always_comb begin
    pos_d    = '0;
    val_d    = '0;
    status_d = ST_OK;
    if (is_count && sat) begin
      status_d = ST_SAT;
    end else if (is_place) begin
      val_d = elem_q;
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        pos_d = pos_ext[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pos_q    <= pos_d;
      val_q    <= val_d;
      status_q <= status_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign position_o     = pos_q;
  assign value_o        = val_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

FILE: src/counting_sort_by_bucket.sv
// ----------------------------------------------------------------------------
// counting_sort_by_bucket
// Stable counting sort engine keyed on the low bucket_bits bits of an element.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its one result
// appears on the result ports for a single cycle with result_valid_o high,
// and the receiver must take it then. Each operation's steps follow from the
// single counter RAM with its registered read: one access per bucket for
// clear, a read then a write per active bucket for prefix and for a single
// update. After reset the engine runs a clearing pass over all MAX_BUCKETS
// buckets with busy high before the first operation is taken; bucket_bits
// may be written at any idle time, also during that pass.
`default_nettype none

module counting_sort_by_bucket import csb_pkg::*; #(
  parameter int unsigned MAX_BUCKETS  = MaxBucketsDef,
  parameter int unsigned MAX_ELEMENTS = MaxElementsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [OpW-1:0]     op_i,
  input  wire logic [ValW-1:0]    element_value_i,
  input  wire logic               cfg_we_i,
  input  wire logic [BitsW-1:0]   cfg_wdata_i,
  output logic                    result_valid_o,
  output logic [PosW-1:0]         position_o,
  output logic [ValW-1:0]         value_o,
  output logic [StatusW-1:0]      status_o
);

  csb_cmd_t cmd;
  csb_sts_t sts;

  csb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  csb_datapath #(
    .MAX_BUCKETS  (MAX_BUCKETS),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .element_value_i (element_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .position_o      (position_o),
    .value_o         (value_o),
    .status_o        (status_o),
    .result_valid_o  (result_valid_o)
  );

endmodule

`default_nettype wire

FILE: src/csb_checker.sv
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks on the counting sort engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_checker import csb_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               result_valid_o,
  input wire logic [PosW-1:0]    position_o,
  input wire logic [StatusW-1:0] status_o
);

  // an emit is always followed by a return to idle, so strobes never abut
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  // a transfer in always makes the engine busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted operation did not raise busy");

  // the result is delivered when the engine has returned to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // a nonzero position only comes from a successful place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (position_o != '0)) |-> (status_o == ST_OK))
    else $error("nonzero position with error status");

endmodule

bind counting_sort_by_bucket csb_checker u_csb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .position_o     (position_o),
  .status_o       (status_o)
);

`default_nettype wire
